[hdl/lpip_pkg.sv]
// ----------------------------------------------------------------------------
// lpip_pkg
// Shared widths, register indexes and the item tag for the lidar point
// projection pipeline.
// ----------------------------------------------------------------------------
`default_nettype none

package lpip_pkg;

   // default fraction bits of the point coordinates
   localparam int POINT_FRAC_BITS_DEF = 16;

   // camera-frame coordinate width (rotation products plus translation)
   localparam int CAM_W = 53;

   // normalised coordinate: Q.20, saturated to +-4.0
   localparam int QBITS  = 22;
   localparam int NORM_W = QBITS + 2;

   // divider latency: input register, one stage per quotient bit, output register
   localparam int DIV_LAT = QBITS + 2;

   // box bound width
   localparam int BOX_W = 12;

   // configuration register indexes
   localparam int CSR_IDX_W = 3;
   localparam logic [CSR_IDX_W-1:0] CSR_ROT_A  = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_ROT_B  = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_ROT_C  = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_TRANS  = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_INTRIN = 3'd4;
   localparam logic [CSR_IDX_W-1:0] CSR_RADIAL = 3'd5;
   localparam logic [CSR_IDX_W-1:0] CSR_TANG   = 3'd6;

   // control and box data that travel with each item
   typedef struct packed {
      logic             vld;
      logic             front;
      logic [BOX_W-1:0] top;
      logic [BOX_W-1:0] bottom;
      logic [BOX_W-1:0] left;
      logic [BOX_W-1:0] right;
   } tag_type;

endpackage

`default_nettype wire

[hdl/lpip_div.sv]
// ----------------------------------------------------------------------------
// lpip_div
// Pipelined restoring divider: num / den for den >= 0 as a Q.20 quotient,
// magnitude truncated, saturated to +-4.0. One quotient bit per stage.
// ----------------------------------------------------------------------------
`default_nettype none

module lpip_div
   import lpip_pkg::*;
(
   input  wire logic                     clock,
   input  wire logic signed [CAM_W-1:0]  num,
   input  wire logic signed [CAM_W-1:0]  den,
   output logic signed [NORM_W-1:0]      quot
);

   localparam int DIV_W = CAM_W + 3;
   localparam logic [NORM_W-1:0] NORM_SAT = {{(NORM_W-1){1'b0}}, 1'b1} << QBITS;

   logic [DIV_W-1:0] rem_ff [0:QBITS];
   logic [DIV_W-1:0] d4_ff  [0:QBITS];
   logic [QBITS-1:0] q_ff   [0:QBITS];
   logic             sat_ff [0:QBITS];
   logic             neg_ff [0:QBITS];

   logic [CAM_W-1:0] mag;
   logic [DIV_W-1:0] rem_in;
   logic [DIV_W-1:0] d4_in;
   logic [NORM_W-1:0] qmag;
   logic signed [NORM_W-1:0] quot_ff;

   // magnitude against four times the divisor: quotient bits then weigh Q.20
   assign mag    = num[CAM_W-1] ? (~num + 1'b1) : num;
   assign rem_in = {3'b000, mag};
   assign d4_in  = {1'b0, den, 2'b00};

   always_ff @(posedge clock) begin
      rem_ff[0] <= rem_in;
      d4_ff[0]  <= d4_in;
      q_ff[0]   <= '0;
      sat_ff[0] <= (rem_in >= d4_in);
      neg_ff[0] <= num[CAM_W-1];
   end

   // one compare and subtract per stage
   for (genvar k = 0; k < QBITS; k++) begin : g_stage
      logic [DIV_W-1:0] trial;
      logic             ge;
      assign trial = {rem_ff[k][DIV_W-2:0], 1'b0};
      assign ge    = (trial >= d4_ff[k]);
      always_ff @(posedge clock) begin
         rem_ff[k+1] <= ge ? (trial - d4_ff[k]) : trial;
         d4_ff[k+1]  <= d4_ff[k];
         q_ff[k+1]   <= {q_ff[k][QBITS-2:0], ge};
         sat_ff[k+1] <= sat_ff[k];
         neg_ff[k+1] <= neg_ff[k];
      end
   end

   // saturate and restore the sign
   assign qmag = sat_ff[QBITS] ? NORM_SAT : {{(NORM_W-QBITS){1'b0}}, q_ff[QBITS]};

   always_ff @(posedge clock) begin
      quot_ff <= neg_ff[QBITS] ? (~qmag + 1'b1) : qmag;
   end

   assign quot = quot_ff;

endmodule

`default_nettype wire

[hdl/lidar_point_image_projection.sv]
// ----------------------------------------------------------------------------
// lidar_point_image_projection
// Projects a lidar point through extrinsics, a pinhole camera with Brown
// distortion and intrinsics to a floored pixel, and tests it against a box.
// ----------------------------------------------------------------------------
//  channel   ports                                   handshake
//  request   req_point_*, req_box_*                  start / busy
//  response  rsp_in_front, rsp_pixel_*, rsp_inside_box  rsp_valid strobe
//  config    csr_index, csr_wdata                    csr_valid / csr_ready
//
//  One item per cycle while busy is low; results leave in the order of their items.
//  Most of the pipeline lies in the two 22-stage restoring dividers (one quotient bit
//  per stage) between the extrinsic stages and the distortion multipliers.
//  Synchronous reset empties the pipeline and clears the configuration and tag
//  registers; busy follows reset. Results cannot be held off, so nothing ever stalls.
// ----------------------------------------------------------------------------
`default_nettype none

module lidar_point_image_projection
   import lpip_pkg::*;
#(
   parameter int POINT_FRAC_BITS = POINT_FRAC_BITS_DEF
)(
   input  wire logic                  clock,
   input  wire logic                  reset,
   // request
   input  wire logic                  start,
   output logic                       busy,
   input  wire logic signed [31:0]    req_point_x,
   input  wire logic signed [31:0]    req_point_y,
   input  wire logic signed [31:0]    req_point_z,
   input  wire logic [BOX_W-1:0]      req_box_top,
   input  wire logic [BOX_W-1:0]      req_box_bottom,
   input  wire logic [BOX_W-1:0]      req_box_left,
   input  wire logic [BOX_W-1:0]      req_box_right,
   // response
   output logic                       rsp_valid,
   output logic                       rsp_in_front,
   output logic signed [15:0]         rsp_pixel_first,
   output logic signed [15:0]         rsp_pixel_second,
   output logic                       rsp_inside_box,
   // configuration
   input  wire logic                  csr_valid,
   output logic                       csr_ready,
   input  wire logic [CSR_IDX_W-1:0]  csr_index,
   input  wire logic [63:0]           csr_wdata
);

   localparam int POST_N   = 10;
   localparam int PIPE_LAT = 3 + DIV_LAT + POST_N + 1;
   localparam int PROD_W   = 50;

   localparam logic signed [59:0] FAC_ONE = 60'sd68719476736;
   localparam logic signed [43:0] FAC_HI  = 44'sd1073741824;
   localparam logic signed [43:0] FAC_LO  = -44'sd1073741824;
   localparam logic signed [30:0] PIX_HI  = 31'sd32767;
   localparam logic signed [30:0] PIX_LO  = -31'sd32768;

   // configuration registers
   logic [53:0] rot_a_ff, rot_b_ff, rot_c_ff;
   logic [62:0] trans_ff;
   logic [63:0] intrin_ff;
   logic [62:0] radial_ff;
   logic [41:0] tang_ff;

   logic accept;

   assign busy      = reset;
   assign csr_ready = ~reset;
   assign accept    = start & ~busy;

   // register writes, index beyond the list ignored
   always_ff @(posedge clock) begin
      if (reset) begin
         rot_a_ff  <= '0;
         rot_b_ff  <= '0;
         rot_c_ff  <= '0;
         trans_ff  <= '0;
         intrin_ff <= '0;
         radial_ff <= '0;
         tang_ff   <= '0;
      end else if (csr_valid && csr_ready) begin
         case (csr_index)
            CSR_ROT_A:  rot_a_ff  <= csr_wdata[53:0];
            CSR_ROT_B:  rot_b_ff  <= csr_wdata[53:0];
            CSR_ROT_C:  rot_c_ff  <= csr_wdata[53:0];
            CSR_TRANS:  trans_ff  <= csr_wdata[62:0];
            CSR_INTRIN: intrin_ff <= csr_wdata;
            CSR_RADIAL: radial_ff <= csr_wdata[62:0];
            CSR_TANG:   tang_ff   <= csr_wdata[41:0];
            default: begin
            end
         endcase
      end
   end

   // register fields
   logic [53:0]        rot_row [0:2];
   logic signed [31:0] pt [0:2];
   logic signed [20:0] k1, k2, k3, p1, p2;
   logic [15:0]        fx, fy, cx, cy;

   assign rot_row[0] = rot_a_ff;
   assign rot_row[1] = rot_b_ff;
   assign rot_row[2] = rot_c_ff;
   assign pt[0] = req_point_x;
   assign pt[1] = req_point_y;
   assign pt[2] = req_point_z;
   assign k1 = radial_ff[20:0];
   assign k2 = radial_ff[41:21];
   assign k3 = radial_ff[62:42];
   assign p1 = tang_ff[20:0];
   assign p2 = tang_ff[41:21];
   assign fx = intrin_ff[15:0];
   assign fy = intrin_ff[31:16];
   assign cx = intrin_ff[47:32];
   assign cy = intrin_ff[63:48];

   // ---------------- extrinsic stages ----------------
   tag_type tag_in;
   tag_type s1_tag_ff, s2_tag_ff, s3_tag_ff;
   tag_type s3_tag_in;
   tag_type dly_ff  [0:DIV_LAT-1];
   tag_type ptag_ff [0:POST_N-1];

   logic signed [PROD_W-1:0] mp_in [0:2][0:2];
   logic signed [PROD_W-1:0] mp_ff [0:2][0:2];
   logic signed [CAM_W-1:0]  tsh_in [0:2];
   logic signed [CAM_W-1:0]  tsh_ff [0:2];
   logic signed [CAM_W-1:0]  sa_ff [0:2];
   logic signed [CAM_W-1:0]  sb_ff [0:2];
   logic signed [CAM_W-1:0]  cam_in [0:2];
   logic signed [CAM_W-1:0]  cam_ff [0:2];

   always_comb begin
      tag_in.vld    = accept;
      tag_in.front  = 1'b0;
      tag_in.top    = req_box_top;
      tag_in.bottom = req_box_bottom;
      tag_in.left   = req_box_left;
      tag_in.right  = req_box_right;
   end

   // rotation products and shifted translation
   always_comb begin
      for (int i = 0; i < 3; i++) begin
         for (int j = 0; j < 3; j++) begin
            mp_in[i][j] = $signed(rot_row[i][18*j +: 18]) * pt[j];
         end
         tsh_in[i] = $signed({{(CAM_W-21){trans_ff[21*i+20]}}, trans_ff[21*i +: 21]})
                     <<< POINT_FRAC_BITS;
      end
   end

   // camera coordinates and depth sign
   always_comb begin
      for (int i = 0; i < 3; i++) begin
         cam_in[i] = sa_ff[i] + sb_ff[i];
      end
      s3_tag_in       = s2_tag_ff;
      s3_tag_in.front = ~cam_in[2][CAM_W-1] & (|cam_in[2]);
   end

   always_ff @(posedge clock) begin
      for (int i = 0; i < 3; i++) begin
         for (int j = 0; j < 3; j++) begin
            mp_ff[i][j] <= mp_in[i][j];
         end
         tsh_ff[i] <= tsh_in[i];
         sa_ff[i]  <= {{(CAM_W-PROD_W){mp_ff[i][0][PROD_W-1]}}, mp_ff[i][0]}
                    + {{(CAM_W-PROD_W){mp_ff[i][1][PROD_W-1]}}, mp_ff[i][1]};
         sb_ff[i]  <= {{(CAM_W-PROD_W){mp_ff[i][2][PROD_W-1]}}, mp_ff[i][2]} + tsh_ff[i];
         cam_ff[i] <= cam_in[i];
      end
   end

   // ---------------- normalisation ----------------
   logic signed [NORM_W-1:0] xn, yn;

   lpip_div u_div_x (
      .clock (clock),
      .num   (cam_ff[0]),
      .den   (cam_ff[2]),
      .quot  (xn)
   );

   lpip_div u_div_y (
      .clock (clock),
      .num   (cam_ff[1]),
      .den   (cam_ff[2]),
      .quot  (yn)
   );

   // tag line: valid bits reset, travel with the data
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_tag_ff <= '0;
         s2_tag_ff <= '0;
         s3_tag_ff <= '0;
         for (int i = 0; i < DIV_LAT; i++) dly_ff[i] <= '0;
         for (int i = 0; i < POST_N; i++) ptag_ff[i] <= '0;
      end else begin
         s1_tag_ff <= tag_in;
         s2_tag_ff <= s1_tag_ff;
         s3_tag_ff <= s3_tag_in;
         dly_ff[0] <= s3_tag_ff;
         for (int i = 1; i < DIV_LAT; i++) dly_ff[i] <= dly_ff[i-1];
         ptag_ff[0] <= dly_ff[DIV_LAT-1];
         for (int i = 1; i < POST_N; i++) ptag_ff[i] <= ptag_ff[i-1];
      end
   end

   // ---------------- distortion and intrinsics ----------------
   logic signed [NORM_W-1:0] xs_ff [0:5];
   logic signed [NORM_W-1:0] ys_ff [0:5];

   logic signed [47:0] pxx_ff, pyy_ff, pxy_ff;
   logic [48:0]        sum_rr;
   logic signed [26:0] r2_ff, xx_ff, yy_ff, xy_ff;
   logic signed [53:0] pr4_ff;
   logic signed [27:0] sx_ff, sy_ff;
   logic signed [26:0] r2c_ff, xyc_ff;
   logic signed [31:0] r4;
   logic signed [58:0] pr6_ff;
   logic signed [47:0] pk1_ff;
   logic signed [52:0] pk2_ff;
   logic signed [47:0] a1_ff, b2_ff;
   logic signed [48:0] a2_ff, b1_ff;
   logic signed [36:0] r6;
   logic signed [57:0] pk3_ff;
   logic signed [53:0] sumk_ff;
   logic signed [51:0] tnx_ff, tny_ff;
   logic signed [59:0] facr;
   logic signed [43:0] facs;
   logic signed [31:0] fac_in, fac_ff;
   logic signed [35:0] ttx_ff, tty_ff, ttxg_ff, ttyg_ff;
   logic signed [55:0] pxf_ff, pyf_ff;
   logic signed [36:0] xd_ff, yd_ff;
   logic signed [53:0] pf_ff, ps_ff;
   logic [54:0]        acc_f, acc_s;
   logic signed [30:0] accs_f, accs_s;
   logic signed [15:0] first_in, second_in, first_ff, second_ff;

   assign sum_rr = {pxx_ff[47], pxx_ff} + {pyy_ff[47], pyy_ff};
   assign r4     = pr4_ff[51:20];
   assign r6     = pr6_ff[56:20];

   // radial factor, clamped to +-1024.0
   assign facr = FAC_ONE + {{6{sumk_ff[53]}}, sumk_ff} + {{2{pk3_ff[57]}}, pk3_ff};
   assign facs = facr[59:16];
   always_comb begin
      if (facs > FAC_HI) begin
         fac_in = 32'sd1073741824;
      end else if (facs < FAC_LO) begin
         fac_in = -32'sd1073741824;
      end else begin
         fac_in = facs[31:0];
      end
   end

   // pixel: add principal point, floor, saturate
   assign acc_f  = {pf_ff[53], pf_ff} + {19'b0, cx, 20'b0};
   assign acc_s  = {ps_ff[53], ps_ff} + {19'b0, cy, 20'b0};
   assign accs_f = acc_f[54:24];
   assign accs_s = acc_s[54:24];

   always_comb begin
      if (accs_f > PIX_HI) begin
         first_in = 16'sh7fff;
      end else if (accs_f < PIX_LO) begin
         first_in = -16'sh8000;
      end else begin
         first_in = accs_f[15:0];
      end
      if (accs_s > PIX_HI) begin
         second_in = 16'sh7fff;
      end else if (accs_s < PIX_LO) begin
         second_in = -16'sh8000;
      end else begin
         second_in = accs_s[15:0];
      end
   end

   always_ff @(posedge clock) begin
      // normalised coordinates carried to the radial scaling
      xs_ff[0] <= xn;
      ys_ff[0] <= yn;
      for (int i = 1; i < 6; i++) begin
         xs_ff[i] <= xs_ff[i-1];
         ys_ff[i] <= ys_ff[i-1];
      end
      // squares and cross term
      pxx_ff <= xn * xn;
      pyy_ff <= yn * yn;
      pxy_ff <= xn * yn;
      // back to Q.20
      r2_ff <= sum_rr[46:20];
      xx_ff <= pxx_ff[46:20];
      yy_ff <= pyy_ff[46:20];
      xy_ff <= pxy_ff[46:20];
      // r^4 product and tangential sums
      pr4_ff <= r2_ff * r2_ff;
      sx_ff  <= {r2_ff[26], r2_ff} + {xx_ff, 1'b0};
      sy_ff  <= {r2_ff[26], r2_ff} + {yy_ff, 1'b0};
      r2c_ff <= r2_ff;
      xyc_ff <= xy_ff;
      // r^6 product, radial and tangential products
      pr6_ff <= r4 * r2c_ff;
      pk1_ff <= k1 * r2c_ff;
      pk2_ff <= k2 * r4;
      a1_ff  <= p1 * xyc_ff;
      a2_ff  <= p2 * sx_ff;
      b1_ff  <= p1 * sy_ff;
      b2_ff  <= p2 * xyc_ff;
      // third radial product, partial sums
      pk3_ff  <= k3 * r6;
      sumk_ff <= {{6{pk1_ff[47]}}, pk1_ff} + {pk2_ff[52], pk2_ff};
      tnx_ff  <= {{3{a1_ff[47]}}, a1_ff, 1'b0} + {{3{a2_ff[48]}}, a2_ff};
      tny_ff  <= {{3{b1_ff[48]}}, b1_ff} + {{3{b2_ff[47]}}, b2_ff, 1'b0};
      // radial factor and tangential offsets
      fac_ff <= fac_in;
      ttx_ff <= tnx_ff[51:16];
      tty_ff <= tny_ff[51:16];
      // radial scaling
      pxf_ff  <= xs_ff[5] * fac_ff;
      pyf_ff  <= ys_ff[5] * fac_ff;
      ttxg_ff <= ttx_ff;
      ttyg_ff <= tty_ff;
      // distorted coordinates
      xd_ff <= {pxf_ff[55], pxf_ff[55:20]} + {ttxg_ff[35], ttxg_ff};
      yd_ff <= {pyf_ff[55], pyf_ff[55:20]} + {ttyg_ff[35], ttyg_ff};
      // focal scaling
      pf_ff <= xd_ff * $signed({1'b0, fx});
      ps_ff <= yd_ff * $signed({1'b0, fy});
      // saturated pixels
      first_ff  <= first_in;
      second_ff <= second_in;
   end

   // ---------------- box test and result register ----------------
   logic in_box;

   assign in_box = (first_ff >= $signed({4'b0, ptag_ff[POST_N-1].top}))
                 && (first_ff < $signed({4'b0, ptag_ff[POST_N-1].bottom}))
                 && (second_ff >= $signed({4'b0, ptag_ff[POST_N-1].left}))
                 && (second_ff < $signed({4'b0, ptag_ff[POST_N-1].right}));

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid <= 1'b0;
      end else begin
         rsp_valid <= ptag_ff[POST_N-1].vld;
      end
      rsp_in_front     <= ptag_ff[POST_N-1].front;
      rsp_pixel_first  <= ptag_ff[POST_N-1].front ? first_ff : '0;
      rsp_pixel_second <= ptag_ff[POST_N-1].front ? second_ff : '0;
      rsp_inside_box   <= ptag_ff[POST_N-1].front & in_box;
   end

   // ---------------- assertions ----------------
   a_result_has_item: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $past(start && !busy, PIPE_LAT))
      else $error("result without an item taken at the pipeline latency");

   a_inside_needs_front: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_inside_box) |-> rsp_in_front)
      else $error("point behind the camera reported inside the box");

   a_behind_zero_pixel: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_in_front)
         |-> (rsp_pixel_first == 16'sd0 && rsp_pixel_second == 16'sd0))
      else $error("point behind the camera with a non-zero pixel");

endmodule

`default_nettype wire
